// ===== rtl/core/wbpe_pkg.sv =====
package wbpe_pkg;

    localparam int SAMP_W = 16;
    localparam int IDX_W  = 17;
    localparam int SUM_W  = 33;
    localparam int SQ_W   = 47;
    localparam int REG_W  = 15;
    localparam int MEAN_W = 24;
    localparam int SIG_W  = 24;
    localparam int HGT_W  = 25;
    localparam int PIDX_W = 14;
    localparam int CNT_W  = 15;

    // register indexes
    localparam logic [1:0] REG_BL_START = 2'd0;
    localparam logic [1:0] REG_BL_END   = 2'd1;
    localparam logic [1:0] REG_PK_START = 2'd2;
    localparam logic [1:0] REG_PK_END   = 2'd3;

    localparam logic [REG_W-1:0] RST_BL_START = 15'd3000;
    localparam logic [REG_W-1:0] RST_BL_END   = 15'd4200;
    localparam logic [REG_W-1:0] RST_PK_START = 15'd4000;
    localparam logic [REG_W-1:0] RST_PK_END   = 15'd5500;

    typedef struct packed {
        logic [REG_W-1:0] bl_start;
        logic [REG_W-1:0] bl_end;
        logic [REG_W-1:0] pk_start;
        logic [REG_W-1:0] pk_end;
    } win_t;

    // accumulated summary of one record
    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]          sq;
        logic [IDX_W-1:0]         n;
        logic signed [SAMP_W-1:0] min;
        logic [PIDX_W-1:0]        min_idx;
        logic                     seen;
        logic [IDX_W-1:0]         count;
        logic                     ovf;
    } rec_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [SIG_W-1:0]  sigma;
        logic [HGT_W-1:0]  height;
        logic [PIDX_W-1:0] peak_idx;
        logic [CNT_W-1:0]  count;
        logic              bl_empty;
        logic              pk_empty;
        logic              ovf;
    } res_t;

endpackage

// ===== rtl/core/wbpe_front.sv =====
module wbpe_front #(
    parameter int MAX_SAMPLES = 16384
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [wbpe_pkg::SAMP_W-1:0] sample,
    input  logic                             last,
    input  wbpe_pkg::win_t                   win,
    input  logic                             q_full,
    output logic                             q_push,
    output wbpe_pkg::rec_t                   q_rec
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [CW-1:0]                      idx_reg, idx_next;
    logic signed [wbpe_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [wbpe_pkg::SQ_W-1:0]          sq_reg, sq_next;
    logic [wbpe_pkg::IDX_W-1:0]         n_reg, n_next;
    logic signed [wbpe_pkg::SAMP_W-1:0] min_reg, min_next;
    logic [wbpe_pkg::PIDX_W-1:0]        midx_reg, midx_next;
    logic                               seen_reg, seen_next;
    logic                               ovf_reg, ovf_next;

    logic                               acc;
    logic                               in_rng, in_bl, in_pk;
    logic [wbpe_pkg::IDX_W-1:0]         iext;
    logic signed [2*wbpe_pkg::SAMP_W-1:0] sqr;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign iext     = wbpe_pkg::IDX_W'(idx_reg);
    assign in_rng   = idx_reg < CW'(MAX_SAMPLES);
    assign in_bl    = in_rng && iext >= wbpe_pkg::IDX_W'(win.bl_start)
                             && iext <  wbpe_pkg::IDX_W'(win.bl_end);
    assign in_pk    = in_rng && iext >= wbpe_pkg::IDX_W'(win.pk_start)
                             && iext <  wbpe_pkg::IDX_W'(win.pk_end);
    assign sqr      = sample * sample;

    // per-sample update of the record summary
    always_comb begin
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        n_next    = n_reg;
        min_next  = min_reg;
        midx_next = midx_reg;
        seen_next = seen_reg;
        ovf_next  = ovf_reg;
        if (in_rng) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            ovf_next = 1'b1;
        end
        if (in_bl) begin
            sum_next = sum_reg + wbpe_pkg::SUM_W'(sample);
            sq_next  = sq_reg + wbpe_pkg::SQ_W'($unsigned(sqr));
            n_next   = n_reg + 1'b1;
        end
        if (in_pk && (!seen_reg || sample < min_reg)) begin
            min_next  = sample;
            midx_next = iext[wbpe_pkg::PIDX_W-1:0];
            seen_next = 1'b1;
        end
    end

    always_comb begin
        q_rec.sum     = sum_next;
        q_rec.sq      = sq_next;
        q_rec.n       = n_next;
        q_rec.min     = min_next;
        q_rec.min_idx = midx_next;
        q_rec.seen    = seen_next;
        q_rec.count   = wbpe_pkg::IDX_W'(idx_next);
        q_rec.ovf     = ovf_next;
    end

    assign q_push = acc && last;

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            idx_reg  <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            n_reg    <= '0;
            min_reg  <= '0;
            midx_reg <= '0;
            seen_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else if (acc) begin
            idx_reg  <= idx_next;
            sum_reg  <= sum_next;
            sq_reg   <= sq_next;
            n_reg    <= n_next;
            min_reg  <= min_next;
            midx_reg <= midx_next;
            seen_reg <= seen_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// ===== rtl/core/wbpe_queue.sv =====
module wbpe_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wbpe_pkg::rec_t din,
    input  logic           pop,
    output wbpe_pkg::rec_t dout,
    output logic           full,
    output logic           empty
);

    wbpe_pkg::rec_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // two-entry record queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/core/wbpe_back.sv =====
module wbpe_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  wbpe_pkg::rec_t q_rec,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output wbpe_pkg::res_t out_res
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_MUL  = 8'b00000010,
        ST_ADD  = 8'b00000100,
        ST_SUB  = 8'b00001000,
        ST_DIVM = 8'b00010000,
        ST_DIVV = 8'b00100000,
        ST_SQRT = 8'b01000000,
        ST_OUT  = 8'b10000000
    } state_t;

    localparam int DVD_W = 80;
    localparam int DVS_W = 34;
    localparam logic [6:0] DIV_LAST  = 7'd79;
    localparam logic [6:0] SQRT_LAST = 7'd23;

    state_t state_reg, state_next;

    wbpe_pkg::rec_t rec_reg;
    wbpe_pkg::res_t pend_reg;
    wbpe_pkg::res_t res_reg;
    logic           valid_reg;

    logic [32:0]       abs_reg;
    logic [40:0]       pql_reg;
    logic [39:0]       pqh_reg;
    logic [63:0]       ss_reg, nq_reg, var_reg;
    logic [DVS_W-1:0]  nn_reg;
    logic [DVD_W-1:0]  dvd_reg, quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, rem_reg, rem_next;
    logic [6:0]        cnt_reg;
    logic signed [41:0] mean_reg;
    logic [47:0]       x_reg, root_reg, bit_reg;

    logic [DVS_W:0]    trial;
    logic              ge;
    logic [41:0]       qz, mean_c;
    logic [47:0]       rb, x_next, root_next;
    logic signed [41:0] minsc, height_c;
    logic              load_out;

    // one restoring division step
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    // floored signed mean from the unsigned quotient
    always_comb begin
        qz     = {1'b0, quo_next[40:0]};
        mean_c = rec_reg.sum[wbpe_pkg::SUM_W-1]
               ? (-qz - 42'(rem_next != '0)) : qz;
    end

    // one digit of the square root
    always_comb begin
        rb = root_reg + bit_reg;
        if (x_reg >= rb) begin
            x_next    = x_reg - rb;
            root_next = (root_reg >> 1) + bit_reg;
        end else begin
            x_next    = x_reg;
            root_next = root_reg >> 1;
        end
    end

    assign minsc    = {{18{rec_reg.min[wbpe_pkg::SAMP_W-1]}}, rec_reg.min, 8'b0};
    assign height_c = mean_reg - minsc;

    assign q_pop    = state_reg == ST_IDLE && !q_empty;
    assign load_out = state_reg == ST_OUT && (!valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) begin
                state_next = (q_rec.n == '0) ? ST_OUT : ST_MUL;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_DIVM;
            ST_DIVM: if (cnt_reg == DIV_LAST) state_next = ST_DIVV;
            ST_DIVV: if (cnt_reg == DIV_LAST) state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == SQRT_LAST) state_next = ST_OUT;
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out)       valid_reg <= 1'b1;
            else if (out_ready) valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (load_out) res_reg <= pend_reg;
        case (state_reg)
            ST_IDLE: begin
                rec_reg           <= q_rec;
                pend_reg.mean     <= '0;
                pend_reg.sigma    <= '0;
                pend_reg.height   <= '0;
                pend_reg.peak_idx <= q_rec.seen ? q_rec.min_idx : '0;
                pend_reg.count    <= q_rec.count[wbpe_pkg::CNT_W-1:0];
                pend_reg.bl_empty <= q_rec.n == '0;
                pend_reg.pk_empty <= !q_rec.seen;
                pend_reg.ovf      <= q_rec.ovf;
            end
            ST_MUL: begin
                abs_reg <= rec_reg.sum[wbpe_pkg::SUM_W-1] ? 33'(-rec_reg.sum)
                                                          : 33'(rec_reg.sum);
                pql_reg <= rec_reg.n * rec_reg.sq[23:0];
                pqh_reg <= rec_reg.n * rec_reg.sq[46:24];
                nn_reg  <= rec_reg.n * rec_reg.n;
            end
            ST_ADD: begin
                nq_reg <= {pqh_reg, 24'b0} + 64'(pql_reg);
                ss_reg <= abs_reg[31:0] * abs_reg[31:0];
            end
            ST_SUB: begin
                var_reg <= nq_reg - ss_reg;
                dvd_reg <= {39'b0, abs_reg, 8'b0};
                dvs_reg <= DVS_W'(rec_reg.n);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIVM: begin
                if (cnt_reg == DIV_LAST) begin
                    mean_reg <= signed'(mean_c);
                    dvd_reg  <= {var_reg, 16'b0};
                    dvs_reg  <= nn_reg;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                end else begin
                    dvd_reg <= dvd_reg << 1;
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            ST_DIVV: begin
                if (cnt_reg == DIV_LAST) begin
                    x_reg    <= quo_next[47:0];
                    root_reg <= '0;
                    bit_reg  <= 48'd1 << 46;
                    cnt_reg  <= '0;
                end else begin
                    dvd_reg <= dvd_reg << 1;
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            ST_SQRT: begin
                x_reg    <= x_next;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                cnt_reg  <= cnt_reg + 7'd1;
                if (cnt_reg == SQRT_LAST) begin
                    pend_reg.mean   <= mean_reg[wbpe_pkg::MEAN_W-1:0];
                    pend_reg.sigma  <= root_next[wbpe_pkg::SIG_W-1:0];
                    pend_reg.height <= rec_reg.seen ? height_c[wbpe_pkg::HGT_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/core/waveform_baseline_peak_extract.sv =====
// Baseline and peak extraction for waveform records. Samples stream in at one
// per cycle while the queue has room; the front accumulates the baseline sums
// and the first minimum of the peak window and hands a record summary to a
// two-entry queue on the last sample. The back computes mean, sigma and height
// with a bit-serial divider (two divisions) and a one-digit-per-cycle square
// root, taking one record at a time. Records longer than the back's time per
// record stream without stall; shorter ones stall the input once the queue
// fills. Window registers are written over APB at byte addresses 0, 4, 8, 12.
module waveform_baseline_peak_extract #(
    parameter int MAX_SAMPLES = 16384
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] baseline_mean, [47:24] baseline_sigma, [72:48] pulse_height,
    // [86:73] peak_index, [101:87] sample_count, [103:102] zero
    output logic [103:0] m_tdata,
    // [0] baseline_empty, [1] peak_empty, [2] overflow
    output logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    wbpe_pkg::win_t win_reg;
    wbpe_pkg::rec_t push_rec, pop_rec;
    wbpe_pkg::res_t res;
    logic           q_push, q_pop, q_full, q_empty;
    logic [1:0]     ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    // window registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.bl_start <= wbpe_pkg::RST_BL_START;
            win_reg.bl_end   <= wbpe_pkg::RST_BL_END;
            win_reg.pk_start <= wbpe_pkg::RST_PK_START;
            win_reg.pk_end   <= wbpe_pkg::RST_PK_END;
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                wbpe_pkg::REG_BL_START: win_reg.bl_start <= pwdata[14:0];
                wbpe_pkg::REG_BL_END:   win_reg.bl_end   <= pwdata[14:0];
                wbpe_pkg::REG_PK_START: win_reg.pk_start <= pwdata[14:0];
                wbpe_pkg::REG_PK_END:   win_reg.pk_end   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            wbpe_pkg::REG_BL_START: prdata = {17'b0, win_reg.bl_start};
            wbpe_pkg::REG_BL_END:   prdata = {17'b0, win_reg.bl_end};
            wbpe_pkg::REG_PK_START: prdata = {17'b0, win_reg.pk_start};
            wbpe_pkg::REG_PK_END:   prdata = {17'b0, win_reg.pk_end};
            default:                prdata = '0;
        endcase
    end

    wbpe_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sample   (signed'(s_tdata)),
        .last     (s_tlast),
        .win      (win_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    wbpe_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_rec),
        .pop     (q_pop),
        .dout    (pop_rec),
        .full    (q_full),
        .empty   (q_empty)
    );

    wbpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rec     (pop_rec),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b0, res.count, res.peak_idx, res.height, res.sigma, res.mean};
    assign m_tuser = {res.ovf, res.pk_empty, res.bl_empty};

    // empty baseline leaves mean, sigma and height zero
    a_bl_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[72:0] == '0)
        else $error("baseline empty with nonzero statistics");

    // empty peak window leaves height and index zero
    a_pk_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[86:48] == '0)
        else $error("peak empty with nonzero height or index");

    // queue is empty after reset, so input is open
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

// ===== dv/waveform_baseline_peak_extract_tb.sv =====
`timescale 1ns / 1ps

module waveform_baseline_peak_extract_tb;

    localparam int MAX_SAMPLES = 16384;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS = 980;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;   // [15:0] sample
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [23:0] mean, [47:24] sigma, [72:48] height, [86:73] peak index,
    // [101:87] sample count, [103:102] zero
    logic [103:0] m_tdata;
    // [0] baseline empty, [1] peak empty, [2] overflow
    logic [2:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    bit calm = 1'b0;        // no idling near the end
    bit hold_req = 1'b0;    // ask the receiver for a long hold-off
    bit held = 1'b0;        // long hold-off already requested

    always #5 aclk = ~aclk;

    waveform_baseline_peak_extract #(.MAX_SAMPLES(MAX_SAMPLES)) dut (.*);

    // Record summary predictor and store of expected summaries
    class pulse_scoreboard;
        logic [wbpe_pkg::REG_W-1:0] bl_start = wbpe_pkg::RST_BL_START;
        logic [wbpe_pkg::REG_W-1:0] bl_end = wbpe_pkg::RST_BL_END;
        logic [wbpe_pkg::REG_W-1:0] pk_start = wbpe_pkg::RST_PK_START;
        logic [wbpe_pkg::REG_W-1:0] pk_end = wbpe_pkg::RST_PK_END;
        int unsigned idx;
        longint sum;
        longint unsigned sq;
        int unsigned n;
        int min_val;
        int unsigned min_idx;
        bit seen, ovf;
        wbpe_pkg::res_t expected_q[$];
        int errors;

        function new();
            clear_record();
        endfunction

        function void clear_record();
            idx = 0; sum = 0; sq = 0; n = 0;
            min_val = 0; min_idx = 0; seen = 0; ovf = 0;
        endfunction

        function void set_window(logic [1:0] sel, logic [wbpe_pkg::REG_W-1:0] v);
            case (sel)
                wbpe_pkg::REG_BL_START: bl_start = v;
                wbpe_pkg::REG_BL_END:   bl_end = v;
                wbpe_pkg::REG_PK_START: pk_start = v;
                wbpe_pkg::REG_PK_END:   pk_end = v;
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // fold one accepted sample into the running record; on the last, queue the expected summary
        function void note_sample(logic signed [15:0] s, logic last);
            longint sv, mean, height, a, q;
            longint unsigned var_n, nn, scaled, mag;
            wbpe_pkg::res_t r;
            sv = s;
            if (idx < MAX_SAMPLES) begin
                if (idx >= bl_start && idx < bl_end) begin
                    sum += sv;
                    sq += longint'(sv * sv);
                    n++;
                end
                if (idx >= pk_start && idx < pk_end && (!seen || sv < min_val)) begin
                    min_val = int'(sv);
                    min_idx = idx;
                    seen = 1;
                end
                idx++;
            end else begin
                ovf = 1;
            end
            if (!last) return;
            mean = 0; height = 0; scaled = 0;
            if (n != 0) begin
                a = sum * 256;
                q = a / longint'(n);
                if ((a % longint'(n)) != 0 && a < 0) q--;
                mean = q;
                mag = (sum < 0) ? -sum : sum;
                var_n = longint'(n) * sq - mag * mag;
                nn = longint'(n) * longint'(n);
                scaled = (var_n / nn) * 65536 + ((var_n % nn) * 65536) / nn;
                if (seen) height = mean - longint'(min_val) * 256;
            end
            r.mean = mean[wbpe_pkg::MEAN_W-1:0];
            r.sigma = wbpe_pkg::SIG_W'(int_sqrt(scaled));
            r.height = height[wbpe_pkg::HGT_W-1:0];
            r.peak_idx = seen ? min_idx[wbpe_pkg::PIDX_W-1:0] : '0;
            r.count = idx[wbpe_pkg::CNT_W-1:0];
            r.bl_empty = (n == 0);
            r.pk_empty = !seen;
            r.ovf = ovf;
            expected_q = {expected_q, r};
            clear_record();
        endfunction

        task report(string what, longint got, longint want);
            $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_summary(logic [103:0] d, logic [2:0] u);
            wbpe_pkg::res_t e;
            if (expected_q.size() == 0) begin
                report("unexpected summary", d[31:0], 0);
                return;
            end
            e = expected_q.pop_front();
            if (d[23:0] != e.mean) report("baseline_mean", d[23:0], e.mean);
            if (d[47:24] != e.sigma) report("baseline_sigma", d[47:24], e.sigma);
            if (d[72:48] != e.height) report("pulse_height", d[72:48], e.height);
            if (d[86:73] != e.peak_idx) report("peak_index", d[86:73], e.peak_idx);
            if (d[101:87] != e.count) report("sample_count", d[101:87], e.count);
            if (d[103:102] != 2'b00) report("pad bits", d[103:102], 0);
            if (u[0] != e.bl_empty) report("baseline_empty", u[0], e.bl_empty);
            if (u[1] != e.pk_empty) report("peak_empty", u[1], e.pk_empty);
            if (u[2] != e.ovf) report("overflow", u[2], e.ovf);
        endtask
    endclass

    pulse_scoreboard sb = new();
    int random_items;

    // monitor both channels at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_summary(m_tdata, m_tuser);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task send_sample(logic [15:0] s, logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= s;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // kind 0: full-range noise, 1: quiet baseline with a negative pulse, 2: constant
    task send_record(int len, int kind);
        logic [15:0] s, level;
        level = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: s = 16'($urandom);
                1: s = 16'(200 + int'($urandom_range(0, 20)) - 10
                       - ((i % 16 > 8) ? int'($urandom_range(0, 3000)) : 0));
                default: s = level;
            endcase
            send_sample(s, i == len - 1);
        end
    endtask

    task drain();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task apb_write(logic [1:0] sel, logic [wbpe_pkg::REG_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= {17'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_window(sel, v);
        @(posedge aclk);
    endtask

    task set_windows(int bs, int be, int ps, int pe);
        apb_write(wbpe_pkg::REG_BL_START, wbpe_pkg::REG_W'(bs));
        apb_write(wbpe_pkg::REG_BL_END, wbpe_pkg::REG_W'(be));
        apb_write(wbpe_pkg::REG_PK_START, wbpe_pkg::REG_W'(ps));
        apb_write(wbpe_pkg::REG_PK_END, wbpe_pkg::REG_W'(pe));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset windows lie beyond a short record: both windows empty
        send_record(3, 0);
        drain();

        // extremes, ties and single-sample records on small windows
        set_windows(0, 4, 1, 6);
        for (int i = 0; i < 5; i++) send_sample(16'h8000, i == 4);
        for (int i = 0; i < 5; i++) send_sample(16'h7fff, i == 4);
        send_sample(16'h7fff, 1'b1);
        send_record(6, 2);
        send_record(6, 1);
        drain();

        // start at or past end empties a window
        set_windows(5, 5, 7, 2);
        send_record(8, 0);
        drain();

        // windows that run far past the end of the record
        set_windows(0, MAX_SAMPLES, 0, MAX_SAMPLES);
        send_record(40, 0);
        drain();

        // random records under changing windows
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            int bs, ps;
            bs = $urandom_range(0, 20);
            ps = $urandom_range(0, 30);
            set_windows(bs, bs + $urandom_range(0, 16), ps, ps + $urandom_range(0, 20));
            if (!held && random_items > 300) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (random_items > 850) calm = 1'b1;
            for (int r = 0; r < 8 && random_items < RANDOM_ITEMS; r++) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
                send_record(len, (r % 4 == 0) ? 0 : ((r % 4 == 3) ? 2 : 1));
                random_items += len;
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/wbpe_pkg.sv
rtl/core/wbpe_front.sv
rtl/core/wbpe_queue.sv
rtl/core/wbpe_back.sv
rtl/core/waveform_baseline_peak_extract.sv
dv/waveform_baseline_peak_extract_tb.sv
